@@ sv/mfd_pkg.sv @@
// Package for the motor feedback frame decoder: slot table, codes and shared types.
`default_nettype none

package mfd_pkg;

	localparam int NUM_SLOTS = 10;
	localparam int SLOT_BITS = 4;
	localparam int ID_BITS   = 11;

	typedef logic [SLOT_BITS-1:0] slot_t;
	typedef logic [ID_BITS-1:0]   frame_id_t;

	// Slots that keep a turn counter
	localparam slot_t SLOT_TURN0 = 4'd4;
	localparam slot_t SLOT_TURN1 = 4'd9;
	localparam slot_t SLOT_LAST  = 4'(NUM_SLOTS - 1);

	// Fixed slot table: bus and standard identifier per slot
	localparam logic [NUM_SLOTS-1:0] SLOT_BUS = 10'b1111_000000;
	localparam frame_id_t SLOT_ID [NUM_SLOTS] = '{
		11'h201, 11'h202, 11'h203, 11'h204, 11'h205,
		11'h208, 11'h206, 11'h205, 11'h206, 11'h207
	};

	// Result of matching one frame against the table
	typedef struct packed {
		logic  hit;
		logic  dual;
		slot_t first_slot;
		slot_t second_slot;
	} match_t;

endpackage

`default_nettype wire

@@ sv/mfd_match.sv @@
// Slot table lookup: finds the first and second slot matching a frame's bus and identifier.
`default_nettype none

module mfd_match
	import mfd_pkg::*;
(
	input  wire logic      bus,
	input  wire frame_id_t frame_id,
	output match_t         match
);

	logic [NUM_SLOTS-1:0] hits;
	slot_t                first_slot;
	slot_t                second_slot;

	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			hits[i] = (SLOT_BUS[i] == bus) && (SLOT_ID[i] == frame_id);
		end
	end

	// lowest matching index reports first, highest second
	always_comb begin
		first_slot  = '0;
		second_slot = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (hits[i]) begin
				first_slot = SLOT_BITS'(i);
			end
		end
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (hits[i]) begin
				second_slot = SLOT_BITS'(i);
			end
		end
	end

	assign match.hit         = |hits;
	assign match.dual        = $countones(hits) > 1;
	assign match.first_slot  = first_slot;
	assign match.second_slot = second_slot;

endmodule

`default_nettype wire

@@ sv/motor_feedback_frame_decoder_core.sv @@
// Top level of the motor feedback frame decoder with multi-turn position unwrap.
//
// Usage:
//   Frame channel (frame_valid/frame_ready) takes one received frame: bus, identifier
//   and seven payload bytes. Result channel (result_valid/result_ready) gives one
//   request per matching motor slot, with 'last' set on the final one of a frame.
//   A frame matching no slot is taken and gives no request.
//   Order: the frame register takes a frame, and the result register then loads
//   from it when the result side is free. A frame matching one slot gives one result;
//   the bus 1 identifier 0x206 matches two slots and gives two results, slot 6 first.
//   Sustained rate: one result per cycle while the result side is ready, set by the
//   single result path that reads and writes the per-slot position and turn state.
//   Stall: when result_ready is low the result register holds, the frame register
//   holds, and frame_ready drops once the frame register is occupied.
//   Reset (arst_n low): previous positions and turn counters clear to zero and
//   both channels empty.
`default_nettype none

module motor_feedback_frame_decoder_core
	import mfd_pkg::*;
#(
	parameter int COUNTS_PER_TURN = 8192,
	parameter int TURN_BITS       = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               frame_valid,
	output logic                    frame_ready,
	input  wire logic               bus,
	input  wire logic [10:0]        frame_id,
	input  wire logic [7:0]         byte_zero,
	input  wire logic [7:0]         byte_one,
	input  wire logic [7:0]         byte_two,
	input  wire logic [7:0]         byte_three,
	input  wire logic [7:0]         byte_four,
	input  wire logic [7:0]         byte_five,
	input  wire logic [7:0]         byte_six,

	output logic                    result_valid,
	input  wire logic               result_ready,
	output logic [3:0]              slot,
	output logic [15:0]             position,
	output logic signed [16:0]      delta,
	output logic [15:0]             speed_raw,
	output logic [15:0]             current_raw,
	output logic [7:0]              temperature,
	output logic signed [16:0]      signed_angle,
	output logic signed [15:0]      turns,
	output logic signed [31:0]      continuous_position,
	output logic                    last
);

	localparam logic signed [17:0] HALF_TURN  = 18'(COUNTS_PER_TURN / 2);
	localparam logic signed [17:0] FULL_TURN  = 18'(COUNTS_PER_TURN);
	localparam logic signed [31:0] TURN_SCALE = 32'(COUNTS_PER_TURN);

	// Frame register
	logic        valid_s1;
	logic        dual_s1;
	slot_t       slot_s1;
	slot_t       second_s1;
	logic [15:0] pos_s1;
	logic [15:0] spd_s1;
	logic [15:0] cur_s1;
	logic [7:0]  tmp_s1;

	// Per-slot state
	logic [15:0]          prev_pos_q [NUM_SLOTS];
	logic [TURN_BITS-1:0] turn_q     [2];

	match_t match;

	mfd_match u_match (
		.bus      (bus),
		.frame_id (frame_id),
		.match    (match)
	);

	// Handshake control
	logic out_free;
	logic emit;
	logic frame_accept;

	assign out_free     = !result_valid || result_ready;
	assign emit         = valid_s1 && out_free;
	assign frame_ready  = !valid_s1 || (emit && !dual_s1);
	assign frame_accept = frame_valid && frame_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			dual_s1  <= 1'b0;
		end else if (frame_accept) begin
			valid_s1 <= match.hit;
			dual_s1  <= match.dual;
		end else if (emit) begin
			// advance to the second slot of a double match, else drop the frame
			if (dual_s1) begin
				dual_s1 <= 1'b0;
			end else begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_accept) begin
			slot_s1   <= match.first_slot;
			second_s1 <= match.second_slot;
			pos_s1    <= {byte_zero, byte_one};
			spd_s1    <= {byte_two, byte_three};
			cur_s1    <= {byte_four, byte_five};
			tmp_s1    <= byte_six;
		end else if (emit && dual_s1) begin
			slot_s1 <= second_s1;
		end
	end

	// Result computation for the slot held in the frame register
	logic                        is_t0;
	logic                        is_t1;
	logic [15:0]                 prev_pos;
	logic signed [16:0]          delta_c;
	logic signed [17:0]          delta_x;
	logic signed [17:0]          pos_x;
	logic signed [17:0]          angle_x;
	logic [TURN_BITS-1:0]        turn_old;
	logic signed [TURN_BITS-1:0] turn_new;
	logic signed [31:0]          turn_ext;
	logic signed [31:0]          cont_c;

	assign is_t0    = slot_s1 == SLOT_TURN0;
	assign is_t1    = slot_s1 == SLOT_TURN1;
	assign prev_pos = prev_pos_q[slot_s1];
	assign delta_c  = 17'({1'b0, pos_s1}) - 17'({1'b0, prev_pos});
	assign delta_x  = 18'(delta_c);
	assign pos_x    = 18'({2'b00, pos_s1});
	assign angle_x  = (pos_x > HALF_TURN) ? (pos_x - FULL_TURN) : pos_x;
	assign turn_old = is_t1 ? turn_q[1] : turn_q[0];

	// step the turn count when the position jumps across the wrap point
	always_comb begin
		priority if (delta_x < -HALF_TURN) begin
			turn_new = turn_old + TURN_BITS'(1);
		end else if (delta_x > HALF_TURN) begin
			turn_new = turn_old - TURN_BITS'(1);
		end else begin
			turn_new = turn_old;
		end
	end

	assign turn_ext = 32'(turn_new);
	assign cont_c   = 32'({16'h0000, pos_s1}) + turn_ext * TURN_SCALE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				prev_pos_q[i] <= '0;
			end
			turn_q[0] <= '0;
			turn_q[1] <= '0;
		end else if (emit) begin
			prev_pos_q[slot_s1] <= pos_s1;
			if (is_t0) begin
				turn_q[0] <= turn_new;
			end
			if (is_t1) begin
				turn_q[1] <= turn_new;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_free) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			slot         <= slot_s1;
			position     <= pos_s1;
			delta        <= delta_c;
			speed_raw    <= spd_s1;
			current_raw  <= cur_s1;
			temperature  <= tmp_s1;
			signed_angle <= angle_x[16:0];
			last         <= !dual_s1;
			if (is_t0 || is_t1) begin
				turns               <= turn_ext[15:0];
				continuous_position <= cont_c;
			end else begin
				turns               <= '0;
				continuous_position <= 32'({16'h0000, pos_s1});
			end
		end
	end

	// Assertions
	a_dual_blocks_frame: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && dual_s1 |-> !frame_ready)
		else $error("frame taken while a double match is still pending");

	a_dual_second: assert property (@(posedge clk) disable iff (!arst_n)
		emit && dual_s1 |=> valid_s1 && !dual_s1)
		else $error("second slot of a double match lost");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> slot <= SLOT_LAST)
		else $error("result slot out of table range");

	a_turns_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && slot != SLOT_TURN0 && slot != SLOT_TURN1 |-> turns == '0)
		else $error("turn count on a slot that does not unwrap");

endmodule

`default_nettype wire

@@ bench/motor_feedback_frame_decoder_checker.sv @@
// Watches both channels of the feedback frame decoder, predicts each result and compares.
module motor_feedback_frame_decoder_checker
	import mfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               frame_valid,
	input  logic               frame_ready,
	input  logic               bus,
	input  logic [10:0]        frame_id,
	input  logic [7:0]         byte_zero,
	input  logic [7:0]         byte_one,
	input  logic [7:0]         byte_two,
	input  logic [7:0]         byte_three,
	input  logic [7:0]         byte_four,
	input  logic [7:0]         byte_five,
	input  logic [7:0]         byte_six,
	input  logic               result_valid,
	input  logic               result_ready,
	input  logic [3:0]         slot,
	input  logic [15:0]        position,
	input  logic signed [16:0] delta,
	input  logic [15:0]        speed_raw,
	input  logic [15:0]        current_raw,
	input  logic [7:0]         temperature,
	input  logic signed [16:0] signed_angle,
	input  logic signed [15:0] turns,
	input  logic signed [31:0] continuous_position,
	input  logic               last,
	output int                 mismatches,
	output int                 outstanding,
	output int                 checked,
	output int                 turn_min,
	output int                 turn_max
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COUNTS_PER_TURN = 8192;
	localparam int HALF_TURN       = COUNTS_PER_TURN / 2;
	localparam int SLOT_COUNT      = 10;
	localparam int MAX_PRINTED     = 40;

	// Own copy of the motor table: identifier per slot, bit k set when slot k sits on bus 1
	localparam logic [10:0] MOTOR_ID [SLOT_COUNT] = '{
		11'h201, 11'h202, 11'h203, 11'h204, 11'h205,
		11'h208, 11'h206, 11'h205, 11'h206, 11'h207
	};
	localparam logic [SLOT_COUNT-1:0] MOTOR_ON_BUS1 = 10'b11_1100_0000;
	localparam int UNWRAP_SLOT_A = 4;
	localparam int UNWRAP_SLOT_B = 9;

	typedef struct packed {
		slot_t              slot;
		logic [15:0]        position;
		logic signed [16:0] delta;
		logic [15:0]        speed_raw;
		logic [15:0]        current_raw;
		logic [7:0]         temperature;
		logic signed [16:0] signed_angle;
		logic signed [15:0] turns;
		logic signed [31:0] continuous_position;
		logic               last;
	} feedback_t;

	feedback_t   pending_feedback [$];
	logic [15:0] prev_position [SLOT_COUNT];
	logic [15:0] turn_count [2];

	initial begin
		foreach (prev_position[i])
			prev_position[i] = '0;
		turn_count[0] = '0;
		turn_count[1] = '0;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatches < MAX_PRINTED)
			$display("[%0t] %s: got %0d, want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// Decode one accepted frame; queue one feedback record per matching slot
	task automatic decode_frame(input logic b, input logic [10:0] id, input logic [15:0] pos,
			input logic [15:0] spd, input logic [15:0] cur, input logic [7:0] tmp);
		feedback_t hits [2];
		int        n;
		int        k;
		int        diff;
		int        ti;
		logic [15:0] cnt;
		n = 0;
		for (k = 0; k < SLOT_COUNT; k++) begin
			if (MOTOR_ON_BUS1[k] == b && MOTOR_ID[k] == id && n < 2) begin
				diff = int'(pos) - int'(prev_position[k]);
				prev_position[k] = pos;
				hits[n].slot = slot_t'(k);
				hits[n].position = pos;
				hits[n].delta = 17'(diff);
				hits[n].speed_raw = spd;
				hits[n].current_raw = cur;
				hits[n].temperature = tmp;
				hits[n].signed_angle = (int'(pos) > HALF_TURN) ?
					17'(int'(pos) - COUNTS_PER_TURN) : 17'(pos);
				hits[n].turns = '0;
				hits[n].continuous_position = 32'(pos);
				ti = (k == UNWRAP_SLOT_A) ? 0 : (k == UNWRAP_SLOT_B) ? 1 : -1;
				if (ti >= 0) begin
					cnt = turn_count[ti];
					if (diff < -HALF_TURN)
						cnt = cnt + 16'd1;
					else if (diff > HALF_TURN)
						cnt = cnt - 16'd1;
					turn_count[ti] = cnt;
					hits[n].turns = $signed(cnt);
					hits[n].continuous_position =
						32'(int'(pos) + int'($signed(cnt)) * COUNTS_PER_TURN);
				end
				hits[n].last = 1'b0;
				n++;
			end
		end
		for (k = 0; k < n; k++) begin
			hits[k].last = (k == n - 1);
			pending_feedback.push_back(hits[k]);
		end
	endtask

	always @(posedge clk) begin
		feedback_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (pending_feedback.size() == 0) begin
					report_mismatch("result with no frame behind it, slot", slot, -1);
				end else begin
					want = pending_feedback.pop_front();
					checked++;
					if (int'(want.turns) < turn_min) turn_min = int'(want.turns);
					if (int'(want.turns) > turn_max) turn_max = int'(want.turns);
					if (slot !== want.slot)
						report_mismatch("slot", slot, want.slot);
					if (position !== want.position)
						report_mismatch("position", position, want.position);
					if (delta !== want.delta)
						report_mismatch("delta", delta, want.delta);
					if (speed_raw !== want.speed_raw)
						report_mismatch("speed_raw", speed_raw, want.speed_raw);
					if (current_raw !== want.current_raw)
						report_mismatch("current_raw", current_raw, want.current_raw);
					if (temperature !== want.temperature)
						report_mismatch("temperature", temperature, want.temperature);
					if (signed_angle !== want.signed_angle)
						report_mismatch("signed_angle", signed_angle, want.signed_angle);
					if (turns !== want.turns)
						report_mismatch("turns", turns, want.turns);
					if (continuous_position !== want.continuous_position)
						report_mismatch("continuous_position", continuous_position,
							want.continuous_position);
					if (last !== want.last)
						report_mismatch("last", last, want.last);
				end
			end
			if (frame_valid && frame_ready)
				decode_frame(bus, frame_id, {byte_zero, byte_one}, {byte_two, byte_three},
					{byte_four, byte_five}, byte_six);
			outstanding <= pending_feedback.size();
		end
	end

endmodule

@@ bench/motor_feedback_frame_decoder_core_tb.sv @@
// Testbench top for the motor feedback frame decoder: stimulus, idling and verdict.
module motor_feedback_frame_decoder_core_tb;
	import mfd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic BUS_FIRST      = 1'b0;
	localparam logic BUS_SECOND     = 1'b1;
	localparam slot_t PAIR_SLOT     = 4'd6;    // shares its identifier with slot 8
	localparam int PHASE_ITEMS      = 200;
	localparam int HOLD_CYCLES      = 300;
	localparam int SWEEP_FRAMES     = 16;
	localparam int DRAIN_CYCLES     = 8;
	localparam int LIMIT_CYCLES     = 1000000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               frame_valid = 1'b0;
	logic               frame_ready;
	logic               bus = 1'b0;
	logic [10:0]        frame_id = '0;
	logic [7:0]         byte_zero = '0;
	logic [7:0]         byte_one = '0;
	logic [7:0]         byte_two = '0;
	logic [7:0]         byte_three = '0;
	logic [7:0]         byte_four = '0;
	logic [7:0]         byte_five = '0;
	logic [7:0]         byte_six = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic [3:0]         slot;
	logic [15:0]        position;
	logic signed [16:0] delta;
	logic [15:0]        speed_raw;
	logic [15:0]        current_raw;
	logic [7:0]         temperature;
	logic signed [16:0] signed_angle;
	logic signed [15:0] turns;
	logic signed [31:0] continuous_position;
	logic               last;

	int mismatches, outstanding, checked, turn_min, turn_max;

	int src_idle = 24;       // percent of cycles the frame side holds back
	int sink_idle = 49;      // percent of cycles the result side refuses
	bit hold_req = 1'b0;     // ask the result side for one long stall
	int hold_left = 0;
	int frames_sent = 0;
	int cycle_count = 0;
	logic [15:0] walk_pos [10];

	motor_feedback_frame_decoder_core u_top (.*);
	motor_feedback_frame_decoder_checker u_check (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Offer one frame request: idle at random first, then hold valid and payload
	// steady until the block takes it. Returns just after the accepting edge.
	task automatic offer(input logic b, input logic [10:0] id, input logic [15:0] pos,
			input logic [15:0] spd, input logic [15:0] cur, input logic [7:0] tmp);
		while ($urandom_range(99) < src_idle) begin
			frame_valid <= 1'b0;
			@(posedge clk);
		end
		frame_valid <= 1'b1;
		bus         <= b;
		frame_id    <= id;
		byte_zero   <= pos[15:8];
		byte_one    <= pos[7:0];
		byte_two    <= spd[15:8];
		byte_three  <= spd[7:0];
		byte_four   <= cur[15:8];
		byte_five   <= cur[7:0];
		byte_six    <= tmp;
		frames_sent++;
		do @(posedge clk); while (!frame_ready);
	endtask

	// Send a frame aimed at one table slot; remember its position for later walks
	task automatic hit_slot(input slot_t k, input logic [15:0] pos);
		walk_pos[k] = pos;
		offer(SLOT_BUS[k], SLOT_ID[k], pos, 16'($urandom), 16'($urandom), 8'($urandom));
	endtask

	// Mostly valid slots with positions that wander around one turn so the
	// unwrap logic steps both ways; the rest is near misses and random ids.
	task automatic random_frame();
		int r;
		int k;
		int step;
		logic [15:0] pos;
		r = $urandom_range(99);
		k = $urandom_range(9);
		case ($urandom_range(3))
			0: pos = 16'($urandom);
			1, 2: begin
				step = $urandom_range(12000);
				pos = 16'((int'(walk_pos[k]) + step - 6000) & 8191);
			end
			default: begin
				case ($urandom_range(5))
					0: pos = 16'd0;
					1: pos = 16'd4096;
					2: pos = 16'd4097;
					3: pos = 16'd8191;
					4: pos = 16'd8192;
					default: pos = 16'hFFFF;
				endcase
			end
		endcase
		if (r < 80)
			hit_slot(slot_t'(k), pos);
		else if (r < 90)
			offer(1'($urandom), SLOT_ID[$urandom_range(9)], pos, 16'($urandom),
				16'($urandom), 8'($urandom));
		else
			offer(1'($urandom), 11'($urandom), pos, 16'($urandom), 16'($urandom),
				8'($urandom));
	endtask

	// Drive one unwrapping slot through a run of turn steps, mostly one way.
	// A climb steps down in position by a bit over half a turn each frame
	// (count up); otherwise step up (count down).
	task automatic turn_sweep(input slot_t k, input bit climb);
		int i;
		logic [15:0] pos;
		for (i = 0; i < SWEEP_FRAMES; i++) begin
			pos = climb ? 16'(65535 - (i % 16) * 4100) : 16'((i % 16) * 4100);
			offer(SLOT_BUS[k], SLOT_ID[k], pos, 16'($urandom), 16'($urandom),
				8'($urandom));
		end
	endtask

	// Result side: random refusals, or one long counted stall when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= sink_idle);
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		foreach (walk_pos[i])
			walk_pos[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: first frame against zero, position extremes, angle edge,
		// turn steps both ways and exactly at half a turn, the shared identifier,
		// and frames that match nothing.
		hit_slot(4'd0, 16'h0000);
		hit_slot(4'd0, 16'hFFFF);
		hit_slot(4'd0, 16'h0000);
		hit_slot(4'd1, 16'd4096);
		hit_slot(4'd2, 16'd4097);
		hit_slot(4'd3, 16'h1234);
		hit_slot(SLOT_TURN0, 16'd8191);
		hit_slot(SLOT_TURN0, 16'd0);
		hit_slot(SLOT_TURN0, 16'd4096);
		hit_slot(SLOT_TURN0, 16'd0);
		hit_slot(SLOT_TURN0, 16'd4097);
		hit_slot(4'd5, 16'hA5A5);
		hit_slot(PAIR_SLOT, 16'h5A5A);
		hit_slot(4'd7, 16'd8192);
		hit_slot(SLOT_TURN1, 16'hFFFF);
		hit_slot(SLOT_TURN1, 16'h0000);
		offer(BUS_SECOND, SLOT_ID[0], 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
		offer(BUS_FIRST, SLOT_ID[PAIR_SLOT], 16'h1111, 16'h2222, 16'h3333, 8'h44);
		offer(BUS_FIRST, 11'h000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
		offer(BUS_SECOND, 11'h7FF, 16'h0000, 16'h0000, 16'h0000, 8'h00);
		offer(BUS_SECOND, SLOT_ID[PAIR_SLOT], 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
		offer(BUS_SECOND, SLOT_ID[PAIR_SLOT], 16'h0000, 16'h0000, 16'h0000, 8'h00);

		// Phase one: frame side light idling, result side heavy; one long stall
		// midway while frames keep coming so the input backs up.
		repeat (PHASE_ITEMS / 2) random_frame();
		hold_req = 1'b1;
		repeat (PHASE_ITEMS - PHASE_ITEMS / 2) random_frame();

		// Phase two: swap the idling
		src_idle = 49;
		sink_idle = 24;
		repeat (PHASE_ITEMS / 2) random_frame();
		hold_req = 1'b1;
		repeat (PHASE_ITEMS - PHASE_ITEMS / 2) random_frame();

		// Phase three and the turn sweeps: back to back, no idling
		src_idle = 0;
		sink_idle = 0;
		repeat (PHASE_ITEMS) random_frame();
		turn_sweep(SLOT_TURN0, 1'b1);
		turn_sweep(SLOT_TURN1, 1'b0);
		frame_valid <= 1'b0;

		// Drain: wait for every predicted result, then keep watching for strays
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d frames, %0d results checked: all slots, the shared id, misses,",
			frames_sent, checked);
		$display("position extremes, long result stalls; turn counts spanned %0d to %0d.",
			turn_min, turn_max);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
